[rtl/tcsp_pkg.sv]
`default_nettype none

package tcsp_pkg;

  // Header layout of the container.
  localparam logic [4:0] HDR_BASE_LEN = 5'd18;
  localparam logic [4:0] HDR_EXT_LEN  = 5'd19;
  localparam logic [4:0] POS_SAT      = 5'd19;
  localparam logic [4:0] MAGIC_LEN    = 5'd5;
  localparam logic [4:0] POS_VERSION  = 5'd5;
  localparam logic [4:0] POS_WIDTH_END  = 5'd10;
  localparam logic [4:0] POS_HEIGHT_END = 5'd14;
  localparam logic [4:0] POS_GRID_W_END = 5'd16;

  localparam logic [7:0] VERSION_1 = 8'd1;
  localparam logic [7:0] VERSION_2 = 8'd2;

  // Compressed blocks are 4x4 texels of 16 bytes each.
  localparam int unsigned BLOCK_SHIFT = 4;
  localparam int unsigned LVL_LIMIT   = 32;

  // Output word layout.
  localparam int unsigned OUT_DATA_W = 128;
  localparam int unsigned OUT_USER_W = 2;

  // Final status codes.
  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_CORRUPT     = 2'd1,
    ST_BAD_MAGIC   = 2'd2,
    ST_BAD_VERSION = 2'd3
  } status_t;

  // Expected magic bytes "CDBC7".
  function automatic logic [7:0] magic_byte(input logic [2:0] idx);
    logic [7:0] val;
    case (idx)
      3'd0:    val = 8'h43;
      3'd1:    val = 8'h44;
      3'd2:    val = 8'h42;
      3'd3:    val = 8'h43;
      3'd4:    val = 8'h37;
      default: val = 8'h00;
    endcase
    return val;
  endfunction

endpackage

`default_nettype wire

[rtl/texture_container_stream_parser.sv]
// Channel | Ports                     | Word contents (lowest bit first)
// input   | in_tvalid/tready/tdata    | tdata: in_byte[7:0]; tlast: in_last
// output  | out_tvalid/tready/tdata   | tdata: payload_byte, mip_level, status,
//         |                           |   image_width, image_height, grid_width,
//         |                           |   grid_height, mip_total, zero fill
//         |                           | tuser: payload_valid, mip_end; tlast: done_res
//
// One input word is accepted per cycle while in_tready is high; its result word is
// registered in the output buffer. The size of the next mip comes from a two-stage
// block-count multiply that runs ahead of the byte stream, so mip changes do not
// stall input. A two-entry output buffer lets input keep flowing while a result
// waits; in_tready drops only when both entries are full. The synchronous
// active-low reset clears all parser state and empties the output buffer.
`default_nettype none

module texture_container_stream_parser
  import tcsp_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [7:0]            in_tdata,   // in_byte
  input  wire logic                  in_tlast,   // in_last
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  // payload_byte, mip_level, status, image_width, image_height,
  // grid_width, grid_height, mip_total, then zero fill
  output logic [OUT_DATA_W-1:0]      out_tdata,
  output logic [OUT_USER_W-1:0]      out_tuser,  // payload_valid, mip_end
  output logic                       out_tlast   // done_res
);

  // Parser state.
  logic [4:0]  pos_r, pos_upd, pos_nxt;
  logic        magic_bad_r, magic_bad_upd, magic_bad_nxt;
  logic [7:0]  version_r, version_upd, version_nxt;
  logic [31:0] width_r, width_upd, width_nxt;
  logic [31:0] height_r, height_upd, height_nxt;
  logic [15:0] grid_w_r, grid_w_upd, grid_w_nxt;
  logic [15:0] grid_h_r, grid_h_upd, grid_h_nxt;
  logic [7:0]  mip_total_r, mip_total_upd, mip_total_nxt;
  logic [7:0]  cur_mip_r, cur_mip_upd, cur_mip_nxt;
  logic [63:0] left_r, left_upd, left_nxt;
  logic        complete_r, complete_upd, complete_nxt;

  // Mip size pipeline.
  logic [7:0]  size_lvl;
  logic [30:0] blk_w_r, blk_h_r;
  logic [61:0] prod_r;
  logic [63:0] mip_size;

  // Per-word result.
  logic [4:0]  hdr_len;
  logic        hdr_ok;
  logic [1:0]  lane;
  logic [63:0] left_cur;
  logic [63:0] left_dec;
  logic        res_pv;
  logic [7:0]  res_pb;
  logic [7:0]  res_ml;
  logic        res_me;
  status_t     res_st;
  logic [OUT_DATA_W-1:0] res_data;

  // Output buffer.
  logic                  push, pop;
  logic                  out_valid_r, skid_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r, skid_data_r;
  logic [OUT_USER_W-1:0] out_user_r, skid_user_r;
  logic                  out_last_r, skid_last_r;

  // Block count along one axis for a given mip level.
  function automatic logic [30:0] blocks_along(input logic [31:0] dim,
                                               input logic [7:0]  lvl);
    logic [31:0] m;
    logic [32:0] sum;
    if (lvl >= 8'(LVL_LIMIT)) begin
      m = 32'd1;
    end else begin
      m = dim >> lvl[4:0];
    end
    if (m == 32'd0) begin
      m = 32'd1;
    end
    sum = {1'b0, m} + 33'd3;
    return sum[32:2];
  endfunction

  // The pipeline works on the current mip until it is loaded, then on the next
  // one, so the size is ready when the current mip ends.
  assign size_lvl = (left_r == 64'd0) ? cur_mip_r : 8'(cur_mip_r + 8'd1);

  always_ff @(posedge clk) begin
    blk_w_r <= blocks_along(width_r, size_lvl);
    blk_h_r <= blocks_along(height_r, size_lvl);
    prod_r  <= 62'(blk_w_r) * 62'(blk_h_r);
  end

  // Saturate at 2^64-1 when the byte count no longer fits.
  assign mip_size = (prod_r[61:60] != 2'b00) ? {64{1'b1}} :
                    {prod_r[59:0], {BLOCK_SHIFT{1'b0}}};

  assign hdr_len = (version_r == VERSION_2) ? HDR_EXT_LEN : HDR_BASE_LEN;
  assign hdr_ok  = !magic_bad_r && (version_r == VERSION_1 || version_r == VERSION_2) &&
                   grid_w_r != 16'd0 && grid_h_r != 16'd0 && mip_total_r != 8'd0;
  assign lane     = 2'(pos_r[1:0] - 2'd2);
  assign left_cur = (left_r == 64'd0) ? mip_size : left_r;
  assign left_dec = left_cur - 64'd1;

  // Header capture and payload tracking for one byte.
  always_comb begin
    pos_upd       = (pos_r < POS_SAT) ? 5'(pos_r + 5'd1) : pos_r;
    magic_bad_upd = magic_bad_r;
    version_upd   = version_r;
    width_upd     = width_r;
    height_upd    = height_r;
    grid_w_upd    = grid_w_r;
    grid_h_upd    = grid_h_r;
    mip_total_upd = mip_total_r;
    cur_mip_upd   = cur_mip_r;
    left_upd      = left_r;
    complete_upd  = complete_r;
    res_pv        = 1'b0;
    res_pb        = 8'd0;
    res_ml        = 8'd0;
    res_me        = 1'b0;
    if (pos_r < MAGIC_LEN) begin
      if (in_tdata != magic_byte(pos_r[2:0])) begin
        magic_bad_upd = 1'b1;
      end
    end else if (pos_r == POS_VERSION) begin
      version_upd   = in_tdata;
      mip_total_upd = (in_tdata == VERSION_1) ? 8'd1 : 8'd0;
    end else if (pos_r < POS_WIDTH_END) begin
      width_upd[{lane, 3'b000} +: 8] = width_r[{lane, 3'b000} +: 8] | in_tdata;
    end else if (pos_r < POS_HEIGHT_END) begin
      height_upd[{lane, 3'b000} +: 8] = height_r[{lane, 3'b000} +: 8] | in_tdata;
    end else if (pos_r < POS_GRID_W_END) begin
      grid_w_upd[{pos_r[0], 3'b000} +: 8] = grid_w_r[{pos_r[0], 3'b000} +: 8] | in_tdata;
    end else if (pos_r < HDR_BASE_LEN) begin
      grid_h_upd[{pos_r[0], 3'b000} +: 8] = grid_h_r[{pos_r[0], 3'b000} +: 8] | in_tdata;
    end else if (pos_r < hdr_len) begin
      mip_total_upd = in_tdata;
    end else if (hdr_ok && !complete_r) begin
      res_pv   = 1'b1;
      res_pb   = in_tdata;
      res_ml   = cur_mip_r;
      left_upd = left_dec;
      if (left_dec == 64'd0) begin
        res_me      = 1'b1;
        cur_mip_upd = 8'(cur_mip_r + 8'd1);
        if (8'(cur_mip_r + 8'd1) == mip_total_r) begin
          complete_upd = 1'b1;
        end
      end
    end
  end

  // Final status, checked in file order.
  always_comb begin
    res_st = ST_OK;
    if (in_tlast) begin
      if (pos_upd < HDR_BASE_LEN) begin
        res_st = ST_CORRUPT;
      end else if (magic_bad_upd) begin
        res_st = ST_BAD_MAGIC;
      end else if (version_upd != VERSION_1 && version_upd != VERSION_2) begin
        res_st = ST_BAD_VERSION;
      end else if (grid_w_upd == 16'd0 || grid_h_upd == 16'd0) begin
        res_st = ST_CORRUPT;
      end else if (version_upd == VERSION_2 &&
                   (pos_upd < HDR_EXT_LEN || mip_total_upd == 8'd0)) begin
        res_st = ST_CORRUPT;
      end else if (!complete_upd) begin
        res_st = ST_CORRUPT;
      end else begin
        res_st = ST_OK;
      end
    end
  end

  assign res_data = {6'd0, mip_total_upd, grid_h_upd, grid_w_upd, height_upd,
                     width_upd, res_st, res_ml, res_pb};

  // A last byte returns the parser to its reset state for the next file.
  always_comb begin
    pos_nxt       = pos_upd;
    magic_bad_nxt = magic_bad_upd;
    version_nxt   = version_upd;
    width_nxt     = width_upd;
    height_nxt    = height_upd;
    grid_w_nxt    = grid_w_upd;
    grid_h_nxt    = grid_h_upd;
    mip_total_nxt = mip_total_upd;
    cur_mip_nxt   = cur_mip_upd;
    left_nxt      = left_upd;
    complete_nxt  = complete_upd;
    if (in_tlast) begin
      pos_nxt       = 5'd0;
      magic_bad_nxt = 1'b0;
      version_nxt   = 8'd0;
      width_nxt     = 32'd0;
      height_nxt    = 32'd0;
      grid_w_nxt    = 16'd0;
      grid_h_nxt    = 16'd0;
      mip_total_nxt = 8'd0;
      cur_mip_nxt   = 8'd0;
      left_nxt      = 64'd0;
      complete_nxt  = 1'b0;
    end
  end

  assign in_tready = !skid_valid_r;
  assign push      = in_tvalid && in_tready;
  assign pop       = out_valid_r && out_tready;

  // Parser state advances on each accepted word.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= 5'd0;
      magic_bad_r <= 1'b0;
      version_r   <= 8'd0;
      width_r     <= 32'd0;
      height_r    <= 32'd0;
      grid_w_r    <= 16'd0;
      grid_h_r    <= 16'd0;
      mip_total_r <= 8'd0;
      cur_mip_r   <= 8'd0;
      left_r      <= 64'd0;
      complete_r  <= 1'b0;
    end else if (push) begin
      pos_r       <= pos_nxt;
      magic_bad_r <= magic_bad_nxt;
      version_r   <= version_nxt;
      width_r     <= width_nxt;
      height_r    <= height_nxt;
      grid_w_r    <= grid_w_nxt;
      grid_h_r    <= grid_h_nxt;
      mip_total_r <= mip_total_nxt;
      cur_mip_r   <= cur_mip_nxt;
      left_r      <= left_nxt;
      complete_r  <= complete_nxt;
    end
  end

  // Output valid flags of the two-entry buffer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (pop) begin
        skid_valid_r <= 1'b0;
      end
    end else if (push) begin
      if (out_valid_r && !pop) begin
        skid_valid_r <= 1'b1;
      end else begin
        out_valid_r <= 1'b1;
      end
    end else if (pop) begin
      out_valid_r <= 1'b0;
    end
  end

  // Output buffer payload.
  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (pop) begin
        out_data_r <= skid_data_r;
        out_user_r <= skid_user_r;
        out_last_r <= skid_last_r;
      end
    end else if (push) begin
      if (out_valid_r && !pop) begin
        skid_data_r <= res_data;
        skid_user_r <= {res_me, res_pv};
        skid_last_r <= in_tlast;
      end else begin
        out_data_r <= res_data;
        out_user_r <= {res_me, res_pv};
        out_last_r <= in_tlast;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;
  assign out_tlast  = out_last_r;

endmodule

`default_nettype wire

[rtl/tcsp_checker.sv]
`default_nettype none

module tcsp_checker
  import tcsp_pkg::*;
(
  input wire logic                  clk,
  input wire logic                  rst_n,
  input wire logic                  in_tready,
  input wire logic                  out_tvalid,
  input wire logic                  out_tready,
  input wire logic [OUT_DATA_W-1:0] out_tdata,
  input wire logic [OUT_USER_W-1:0] out_tuser,
  input wire logic                  out_tlast
);

  // A stalled result word holds its contents.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) &&
      $stable(out_tuser) && $stable(out_tlast))
    else $error("stalled output word changed");

  // Reset empties the output buffer.
  assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

  // Input is only held off while a result is pending.
  assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid)
    else $error("input stalled with empty output");

  // Without a payload byte the payload fields are zero.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> out_tdata[15:0] == 16'd0 && !out_tuser[1])
    else $error("payload fields set without payload byte");

  // Status is only reported on the last word of a file.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> out_tdata[17:16] == ST_OK)
    else $error("status set before end of file");

endmodule

bind texture_container_stream_parser tcsp_checker u_tcsp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);

`default_nettype wire
